// ----- design/kch_pkg.sv -----
// kch_pkg: shared types for the k-mer count histogram core
// no dependencies; imported by kch_window, kch_table, the top level and the checker
package kch_pkg;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // width of the k-mer length register
  localparam int unsigned KLEN_W = 4;
  localparam logic [KLEN_W-1:0] KLEN_RESET = 4'd3;

  // commands from the front end to the table
  typedef struct packed {
    logic inc;  // increment the counter at idx
    logic rd;   // read the counter at idx
    logic clr;  // start a clearing sweep
  } tbl_cmd_t;

  // status from the table back to the front end
  typedef struct packed {
    logic clearing;  // sweep in progress, no requests taken
    logic rd_pend;   // a read is in the second stage
  } tbl_stat_t;

endpackage

// ----- design/kch_window.sv -----
// kch_window: base window shift register and fill count, forms the counter index
// depends on kch_pkg
module kch_window #(
  parameter int unsigned MAX_K = 8,
  parameter int unsigned IDX_W = 2 * MAX_K,
  parameter int unsigned KW    = $clog2(MAX_K + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic             clr_i,
  input  logic [1:0]       base_i,
  input  logic [KW-1:0]    k_i,
  input  logic [IDX_W-1:0] mask_i,
  output logic             cnt_en_o,
  output logic [IDX_W-1:0] cnt_idx_o
);
  import kch_pkg::*;

  logic [IDX_W-1:0] window_q, window_d;
  logic [KW-1:0]    fill_q, fill_d;

  assign window_d = (window_q << 2) | IDX_W'(base_i);
  assign fill_d   = (fill_q < KW'(MAX_K)) ? fill_q + KW'(1) : fill_q;

  assign cnt_en_o  = push_i && (fill_d >= k_i);
  assign cnt_idx_o = window_d & mask_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      fill_q   <= '0;
    end else if (push_i) begin
      window_q <= window_d;
      fill_q   <= fill_d;
    end else if (clr_i) begin
      // window contents stay, only the fill count restarts
      fill_q <= '0;
    end
  end

endmodule

// ----- design/kch_table.sv -----
// kch_table: counter memory with read-modify-write, forwarding and clearing sweep
// depends on kch_pkg
module kch_table #(
  parameter int unsigned IDX_W      = 16,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  kch_pkg::tbl_cmd_t           cmd_i,
  input  logic [IDX_W-1:0]            idx_i,
  output kch_pkg::tbl_stat_t          stat_o,
  output logic                        rd_valid_o,
  output logic [COUNT_BITS-1:0]       rd_data_o
);
  import kch_pkg::*;

  localparam int unsigned DEPTH = 1 << IDX_W;

  logic [COUNT_BITS-1:0] mem_q [DEPTH];
  logic [COUNT_BITS-1:0] rdata_q;

  logic                  s1_inc_q, s1_rd_q;
  logic [IDX_W-1:0]      s1_idx_q;
  logic                  fwd_q;
  logic [COUNT_BITS-1:0] fwd_data_q;

  logic                  clr_q;
  logic [IDX_W-1:0]      clr_cnt_q;

  logic [COUNT_BITS-1:0] cur, inc_val, wr_data;
  logic [IDX_W-1:0]      wr_addr;
  logic                  wr_en;

  // write in stage two lands on the same edge as the next read: forward it
  assign cur     = fwd_q ? fwd_data_q : rdata_q;
  assign inc_val = (&cur) ? cur : cur + COUNT_BITS'(1);

  assign wr_en   = s1_inc_q || clr_q;
  assign wr_addr = clr_q ? clr_cnt_q : s1_idx_q;
  assign wr_data = clr_q ? '0 : inc_val;

  always_ff @(posedge clk_i) begin
    if (cmd_i.inc || cmd_i.rd) begin
      rdata_q <= mem_q[idx_i];
    end
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q   <= idx_i;
    fwd_data_q <= inc_val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_inc_q  <= 1'b0;
      s1_rd_q   <= 1'b0;
      fwd_q     <= 1'b0;
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      s1_inc_q <= cmd_i.inc;
      s1_rd_q  <= cmd_i.rd;
      fwd_q    <= s1_inc_q && (s1_idx_q == idx_i);
      if (cmd_i.clr) begin
        clr_q     <= 1'b1;
        clr_cnt_q <= '0;
      end else if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + IDX_W'(1);
        if (&clr_cnt_q) begin
          clr_q <= 1'b0;
        end
      end
    end
  end

  assign stat_o.clearing = clr_q;
  assign stat_o.rd_pend  = s1_rd_q;
  assign rd_valid_o      = s1_rd_q;
  assign rd_data_o       = cur;

endmodule

// ----- design/kmer_count_histogram_core.sv -----
// kmer_count_histogram_core: top level of the k-mer count histogram
// depends on kch_pkg, kch_window, kch_table
//
//   channel   handshake                 payload
//   ---------------------------------------------------------------------
//   in        in_valid_i / in_ready_o   opcode_i, base_code_i, query_kmer_i
//   out       out_valid_o / out_ready_i kmer_count_o, count_saturated_o
//   cfg       cfg_wr_en_i               cfg_wr_data_i (kmer_length)
//
// a push may follow a push or a read back to back; a read result passes through the
// table read register and then the output register; a read is not taken while the
// previous read is in the table's second stage or an untaken result holds the output
// reset and each clear request start a sweep over all 4**MAX_K counters (65536 at the
// default) that zeroes one counter per cycle; no request is taken during it
// pushes and clears are taken while a result waits on the output
module kmer_count_histogram_core #(
  parameter int unsigned MAX_K      = 8,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_wr_en_i,
  input  logic [kch_pkg::KLEN_W-1:0]  cfg_wr_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  opcode_i,
  input  logic [1:0]                  base_code_i,
  input  logic [15:0]                 query_kmer_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [31:0]                 kmer_count_o,
  output logic                        count_saturated_o
);
  import kch_pkg::*;

  localparam int unsigned IDX_W = 2 * MAX_K;
  localparam int unsigned KW    = $clog2(MAX_K + 1);

  // k-mer length register
  logic [KLEN_W-1:0] klen_q;
  logic [KW-1:0]     k_eff;
  logic [IDX_W-1:0]  kmask;

  // request decode
  op_e              op;
  logic             accept, rd_ok;
  logic             win_en;
  logic [IDX_W-1:0] win_idx, qry_idx;
  tbl_cmd_t         cmd;
  tbl_stat_t        stat;

  // table read result and output register
  logic                  tbl_rd_valid;
  logic [COUNT_BITS-1:0] tbl_rd_data;
  logic                  out_valid_q;
  logic [31:0]           out_count_q;
  logic                  out_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      klen_q <= KLEN_RESET;
    end else if (cfg_wr_en_i) begin
      klen_q <= cfg_wr_data_i;
    end
  end

  // zero acts as one, anything above MAX_K acts as MAX_K
  always_comb begin
    if (klen_q == '0) begin
      k_eff = KW'(1);
    end else if (klen_q > KLEN_W'(MAX_K)) begin
      k_eff = KW'(MAX_K);
    end else begin
      k_eff = KW'(klen_q);
    end
  end

  // low 2k bits select the counter
  assign kmask = ~({IDX_W{1'b1}} << {k_eff, 1'b0});

  assign op = op_e'(opcode_i);

  // a read needs the output slot free by the time its data comes back
  assign rd_ok      = !stat.rd_pend && (!out_valid_q || out_ready_i);
  assign in_ready_o = !stat.clearing && ((op != OP_READ) || rd_ok);
  assign accept     = in_valid_i && in_ready_o;

  kch_window #(
    .MAX_K (MAX_K),
    .IDX_W (IDX_W),
    .KW    (KW)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (accept && (op == OP_PUSH)),
    .clr_i     (accept && (op == OP_CLEAR)),
    .base_i    (base_code_i),
    .k_i       (k_eff),
    .mask_i    (kmask),
    .cnt_en_o  (win_en),
    .cnt_idx_o (win_idx)
  );

  // query widened or cut to the index width, then masked to 2k bits
  assign qry_idx = IDX_W'(query_kmer_i) & kmask;

  assign cmd.inc = win_en;
  assign cmd.rd  = accept && (op == OP_READ);
  assign cmd.clr = accept && (op == OP_CLEAR);

  kch_table #(
    .IDX_W      (IDX_W),
    .COUNT_BITS (COUNT_BITS)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .idx_i      (cmd.rd ? qry_idx : win_idx),
    .stat_o     (stat),
    .rd_valid_o (tbl_rd_valid),
    .rd_data_o  (tbl_rd_data)
  );

  // output register, parts the table from the consumer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (tbl_rd_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_rd_valid) begin
      out_count_q <= 32'(tbl_rd_data);
      out_sat_q   <= &tbl_rd_data;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign kmer_count_o      = out_count_q;
  assign count_saturated_o = out_sat_q;

endmodule

// ----- design/kch_checker.sv -----
// kch_checker: port-level checks for kmer_count_histogram_core, bound to the top level
// depends on kch_pkg and kmer_count_histogram_core
module kch_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  opcode_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] kmer_count_o,
  input logic        count_saturated_o
);
  import kch_pkg::*;

  // a result waiting on the output holds still
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kmer_count_o)
      && $stable(count_saturated_o))
    else $error("result changed while stalled");

  // the clearing sweep blocks requests right after reset
  a_reset_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !in_ready_o)
    else $error("request taken during reset sweep");

  // a clear request starts the sweep
  a_clear_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (opcode_i == OP_CLEAR) |=> !in_ready_o)
    else $error("request taken right after clear");

  // a read delivers its result through the table read stage and the output register
  a_read_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (opcode_i == OP_READ) |=> ##1 out_valid_o)
    else $error("read result missing");

endmodule

bind kmer_count_histogram_core kch_checker u_kch_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .opcode_i          (opcode_i),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .kmer_count_o      (kmer_count_o),
  .count_saturated_o (count_saturated_o)
);

// ----- tb/tb_kmer_count_histogram_core.sv -----
// tb_kmer_count_histogram_core: self-checking testbench for the k-mer count histogram core
// depends on kch_pkg and kmer_count_histogram_core; runs a directed table, then
// randomized requests under several k-mer lengths and idling phases
module tb_kmer_count_histogram_core;
  timeunit 1ns;
  timeprecision 1ps;

  import kch_pkg::*;

  localparam int unsigned MAX_K = 8;
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
  localparam int unsigned SEGMENTS = 8;
  localparam int unsigned SEG_REQUESTS = 52;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HISTORY_DEPTH = 16;

  // one returned count as the output channel carries it
  typedef struct packed {
    logic [31:0] count;
    logic        sat;
  } count_exp_t;

  // one row of the directed table; typed rows carry their own expected count
  typedef struct packed {
    op_e         op;
    logic [1:0]  base;
    logic [15:0] query;
    logic        typed;
    logic [31:0] count;
    logic        sat;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 23;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_wr_en_i = 1'b0;
  logic [KLEN_W-1:0]   cfg_wr_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [1:0]          opcode_i = OP_NONE;
  logic [1:0]          base_code_i = '0;
  logic [15:0]         query_kmer_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [31:0]         kmer_count_o;
  logic                count_saturated_o;

  kmer_count_histogram_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_wr_en_i      (cfg_wr_en_i),
    .cfg_wr_data_i    (cfg_wr_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .opcode_i         (opcode_i),
    .base_code_i      (base_code_i),
    .query_kmer_i     (query_kmer_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kmer_count_o     (kmer_count_o),
    .count_saturated_o(count_saturated_o)
  );

  // ---------------------------------------------------------------------------
  // k-mer counting model: length register, base window, fill count, counters
  // ---------------------------------------------------------------------------
  logic [KLEN_W-1:0]   klen_model;
  logic [15:0]         win_model;
  int unsigned         fill_model;
  logic [31:0]         tally_model [int unsigned];  // missing entry reads as zero
  logic [15:0]         recent_kmers [$];            // recently counted codes, for queries
  count_exp_t          expected_counts [$];         // counts still owed by the core

  // idling knobs, in percent
  int unsigned         send_idle_pct = 0;
  int unsigned         recv_stall_pct = 0;

  // bookkeeping
  int unsigned         mismatches = 0;
  int unsigned         n_push = 0;
  int unsigned         n_read = 0;
  int unsigned         n_clear = 0;
  int unsigned         n_ignored = 0;
  int unsigned         n_checked = 0;

  // directed table, written at the reset length of 3
  dir_row_t directed_rows [DIR_ROWS] = '{
    // reads straight after reset: nothing counted yet, both query extremes
    '{OP_READ,  2'd0, 16'h0000, 1'b1, 32'd0, 1'b0},
    '{OP_READ,  2'd3, 16'hFFFF, 1'b1, 32'd0, 1'b0},
    // A C G T: counts ACG and CGT
    '{OP_PUSH,  2'd0, 16'h0000, 1'b0, 32'd0, 1'b0},
    '{OP_PUSH,  2'd1, 16'h0000, 1'b0, 32'd0, 1'b0},
    '{OP_PUSH,  2'd2, 16'h0000, 1'b0, 32'd0, 1'b0},
    '{OP_PUSH,  2'd3, 16'h0000, 1'b0, 32'd0, 1'b0},
    '{OP_READ,  2'd0, 16'h0006, 1'b0, 32'd0, 1'b0},
    // junk above the k-mer bits must be masked off
    '{OP_READ,  2'd0, 16'hFFDB, 1'b0, 32'd0, 1'b0},
    // unused opcode: dropped, no result
    '{OP_NONE,  2'd0, 16'h0006, 1'b0, 32'd0, 1'b0},
    // run of T: same k-mer back to back exercises the counter forwarding
    '{OP_PUSH,  2'd3, 16'h0000, 1'b0, 32'd0, 1'b0},
    '{OP_PUSH,  2'd3, 16'h0000, 1'b0, 32'd0, 1'b0},
    '{OP_PUSH,  2'd3, 16'h0000, 1'b0, 32'd0, 1'b0},
    '{OP_PUSH,  2'd3, 16'h0000, 1'b0, 32'd0, 1'b0},
    '{OP_READ,  2'd0, 16'h003F, 1'b0, 32'd0, 1'b0},
    // clear wipes the table; window refills before counting again
    '{OP_CLEAR, 2'd0, 16'h0000, 1'b0, 32'd0, 1'b0},
    '{OP_READ,  2'd0, 16'h003F, 1'b1, 32'd0, 1'b0},
    '{OP_PUSH,  2'd0, 16'h0000, 1'b0, 32'd0, 1'b0},
    '{OP_PUSH,  2'd0, 16'h0000, 1'b0, 32'd0, 1'b0},
    '{OP_READ,  2'd0, 16'h0000, 1'b1, 32'd0, 1'b0},
    '{OP_PUSH,  2'd0, 16'h0000, 1'b0, 32'd0, 1'b0},
    '{OP_READ,  2'd0, 16'h0000, 1'b0, 32'd0, 1'b0},
    '{OP_NONE,  2'd3, 16'hFFFF, 1'b0, 32'd0, 1'b0},
    '{OP_READ,  2'd2, 16'hFFC0, 1'b0, 32'd0, 1'b0}
  };

  // length settings per segment; 0 acts as 1 and anything above MAX_K as MAX_K
  logic [KLEN_W-1:0] seg_klen [SEGMENTS] = '{4'd1, 4'd15, 4'd0, 4'd5, 4'd8, 4'd2, 4'd0, 4'd4};

  function automatic int unsigned eff_k();
    if (klen_model == '0) return 1;
    if (klen_model > MAX_K) return MAX_K;
    return int'(unsigned'(klen_model));
  endfunction

  function automatic logic [15:0] kmer_mask(input int unsigned k);
    return 16'((32'd1 << (2 * k)) - 32'd1);
  endfunction

  function automatic logic [31:0] tally_at(input logic [15:0] idx);
    return tally_model.exists(idx) ? tally_model[idx] : 32'd0;
  endfunction

  // advance the model by one request; produced is set when a count comes back
  function automatic void predict_kmer_op(input logic [1:0] op, input logic [1:0] base,
                                          input logic [15:0] query, output bit produced,
                                          output count_exp_t res);
    int unsigned k;
    logic [15:0] mask;
    logic [15:0] idx;
    logic [31:0] cur;
    k = eff_k();
    mask = kmer_mask(k);
    produced = 1'b0;
    res = '0;
    case (op_e'(op))
      OP_PUSH: begin
        win_model = {win_model[13:0], base};
        if (fill_model < MAX_K) fill_model++;
        if (fill_model >= k) begin
          idx = win_model & mask;
          cur = tally_at(idx);
          // counters stick at their maximum
          if (cur != COUNT_MAX) tally_model[idx] = cur + 32'd1;
          recent_kmers.push_back(idx);
          if (recent_kmers.size() > HISTORY_DEPTH) void'(recent_kmers.pop_front());
        end
      end
      OP_READ: begin
        idx = query & mask;
        cur = tally_at(idx);
        produced = 1'b1;
        res.count = cur;
        res.sat = (cur == COUNT_MAX);
      end
      OP_CLEAR: begin
        // window contents survive, only the fill count restarts
        tally_model.delete();
        fill_model = 0;
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // clock, receiver and result checking
  // ---------------------------------------------------------------------------
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // receiver stalls at the rate set for the current phase
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // every accepted count is compared with the oldest one owed
  always @(posedge clk_i) begin
    count_exp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_checked++;
      if (expected_counts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected count %0d sat %0b with no read outstanding",
                   kmer_count_o, count_saturated_o);
      end else begin
        want = expected_counts.pop_front();
        if (kmer_count_o !== want.count || count_saturated_o !== want.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("count mismatch: expected %0d sat %0b, got %0d sat %0b",
                     want.count, want.sat, kmer_count_o, count_saturated_o);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // request driving
  // ---------------------------------------------------------------------------

  // optional sender gap, then hold the request until it is taken; typed rows
  // supply their own expected count, the rest come from the model
  task automatic send_request(input logic [1:0] op, input logic [1:0] base,
                              input logic [15:0] query, input logic typed,
                              input count_exp_t typed_res);
    bit produced;
    count_exp_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    base_code_i  <= base;
    query_kmer_i <= query;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_kmer_op(op, base, query, produced, res);
    if (produced) expected_counts.push_back(typed ? typed_res : res);
    case (op_e'(op))
      OP_PUSH:  n_push++;
      OP_READ:  n_read++;
      OP_CLEAR: n_clear++;
      default:  n_ignored++;
    endcase
  endtask

  // stop sending and wait for every outstanding count
  task automatic drain_counts();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_counts.size() != 0);
  endtask

  // length register is only touched with the core idle: counts drained, the
  // pipeline flushed and no clearing sweep running
  task automatic set_kmer_length(input logic [KLEN_W-1:0] klen);
    drain_counts();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= klen;
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b0;
    klen_model = klen;
  endtask

  // one random request; returns 0 for the unused opcode, which does not count
  task automatic random_request(output bit counted);
    int unsigned pick;
    logic [1:0]  base;
    logic [15:0] query;
    logic [15:0] mask;
    pick = $urandom_range(99);
    mask = kmer_mask(eff_k());
    counted = 1'b1;
    if (pick < 4) begin
      send_request(OP_NONE, 2'($urandom), 16'($urandom), 1'b0, '0);
      counted = 1'b0;
    end else if (pick < 30) begin
      // mostly query a k-mer that was really counted, with junk in the high bits
      if (recent_kmers.size() != 0 && $urandom_range(3) != 0)
        query = recent_kmers[$urandom_range(recent_kmers.size() - 1)]
                | (16'($urandom) & ~mask);
      else
        query = 16'($urandom);
      send_request(OP_READ, 2'($urandom), query, 1'b0, '0);
    end else begin
      // repeated bases give repeated k-mers on consecutive pushes
      if ($urandom_range(9) < 3)
        base = win_model[1:0];
      else
        base = 2'($urandom);
      send_request(OP_PUSH, base, 16'($urandom), 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned n;
    int unsigned clear_at;
    bit counted;
    bit clear_seg;
    logic [KLEN_W-1:0] klen;
    count_exp_t typed_res;

    klen_model = KLEN_RESET;
    win_model  = '0;
    fill_model = 0;

    // hold reset, then release it; the core then sweeps its counters before taking requests
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table at the reset length
    foreach (directed_rows[i]) begin
      typed_res.count = directed_rows[i].count;
      typed_res.sat   = directed_rows[i].sat;
      send_request(directed_rows[i].op, directed_rows[i].base, directed_rows[i].query,
                   directed_rows[i].typed, typed_res);
    end

    // random segments: a new length each, idling phase changes every two;
    // the first of each pair also clears the table once somewhere inside
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      klen = (seg == 6) ? KLEN_W'($urandom_range(15)) : seg_klen[seg];
      set_kmer_length(klen);
      case (seg / 2)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      clear_seg = (seg % 2 == 0);
      clear_at  = $urandom_range(5, SEG_REQUESTS - 6);
      n = 0;
      while (n < SEG_REQUESTS) begin
        if (clear_seg && n == clear_at) begin
          send_request(OP_CLEAR, 2'($urandom), 16'($urandom), 1'b0, '0);
          n++;
        end else begin
          // hold off mid-segment until every owed count is back
          if (seg == 1 && n == SEG_REQUESTS / 2) drain_counts();
          random_request(counted);
          if (counted) n++;
        end
      end
    end

    // wind down: all counts in, then let the pipeline settle
    drain_counts();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d pushes, %0d reads, %0d clears and %0d unused opcodes over %0d lengths",
             n_push, n_read, n_clear, n_ignored, SEGMENTS + 1);
    $display("%0d counts checked, %0d mismatches", n_checked, mismatches);
    if (mismatches == 0)
      $display("tb_kmer_count_histogram_core passed");
    else
      $display("tb_kmer_count_histogram_core failed");
    $finish;
  end

  // watchdog: six clearing sweeps plus all requests fit many times over
  initial begin
    #20_000_000;
    $display("tb_kmer_count_histogram_core failed");
    $finish;
  end

endmodule

// ----- kmer_count_histogram_core.f -----
design/kch_pkg.sv
design/kch_window.sv
design/kch_table.sv
design/kmer_count_histogram_core.sv
design/kch_checker.sv
tb/tb_kmer_count_histogram_core.sv
